// File: hw/rtl/pfba_pkg.sv
// shared types and constants of the page frame bitmap allocator
// no dependencies; imported by the interfaces, the allocator top and its testbench
package pfba_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned FRAME_W = 12;

  localparam logic [7:0] FULL_BYTE = 8'hff;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLAIM = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MOD,
    ST_DONE
  } state_e;

endpackage

// File: hw/rtl/pfba_if.sv
// valid/ready channels of the allocator: request items and result items
// depends on pfba_pkg for the field widths
interface pfba_req_if import pfba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [FRAME_W-1:0] frame_number;

  modport source (output valid, cmd, frame_number, input ready);
  modport sink   (input valid, cmd, frame_number, output ready);
endinterface

interface pfba_rsp_if import pfba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] alloc_frame;
  logic               status;

  modport source (output valid, alloc_frame, status, input ready);
  modport sink   (input valid, alloc_frame, status, output ready);
endinterface

// File: hw/rtl/pfba_ram.sv
// generic single-write, single-read ram with a registered read port
// no dependencies
module pfba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/page_frame_bitmap_allocator_top.sv
// page frame allocator: usage bitmap in a byte-wide ram, byte search hint in a register
// depends on pfba_pkg, pfba_if (pfba_req_if, pfba_rsp_if) and pfba_ram
// steps: free and claim of an in-range frame read, modify and write back their byte, other
//   commands and out-of-range frames go straight to the done state, allocate reads bytes
//   from the hint up to the first one not full, one byte read per cycle through the single
//   ram read port; the done state hands the result on once the output register is free,
//   and a result pending there does not block the next item from being taken and worked
//   up to its own done state
// reset: a clearing pass writes zero to every bitmap byte, no item is taken meanwhile;
//   the hint resets to byte zero
module page_frame_bitmap_allocator_top import pfba_pkg::*; #(
  parameter int unsigned FRAMES = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pfba_req_if.sink       req_i,
  pfba_rsp_if.source     rsp_o
);

  localparam int unsigned NBytes = (FRAMES + 7) / 8;
  localparam int unsigned BW     = (NBytes > 1) ? $clog2(NBytes) : 1;
  localparam logic [BW-1:0] LastByte = BW'(NBytes - 1);
  // bit positions past FRAMES in the last byte always read as used
  localparam logic [7:0] PadMask = (FRAMES % 8 == 0) ? 8'h00 : 8'(8'hff << (FRAMES % 8));

  state_e state_q, state_d;
  logic [BW-1:0] addr_q, addr_d;
  logic [BW-1:0] hint_q, hint_d;
  cmd_e cmd_q, cmd_d;
  logic [2:0] bit_q, bit_d;
  logic [FRAME_W-1:0] res_frame_q, res_frame_d;
  logic res_status_q, res_status_d;
  logic out_valid_q, out_valid_d;
  logic [FRAME_W-1:0] out_frame_q, out_frame_d;
  logic out_status_q, out_status_d;

  logic ram_we;
  logic [7:0] ram_wdata;
  logic [7:0] ram_rdata;

  logic accept;
  logic out_free;
  logic in_range;
  logic [31:0] in_byte_w;
  logic [BW-1:0] in_byte;
  logic [7:0] seen;
  logic found;
  logic [2:0] low_bit;
  logic [31:0] alloc_w;
  logic [7:0] bit_mask;

  pfba_ram #(
    .Width (8),
    .Depth (NBytes)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_d),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready      = (state_q == ST_IDLE);
  assign accept           = req_i.valid && req_i.ready;
  assign out_free         = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.alloc_frame = out_frame_q;
  assign rsp_o.status     = out_status_q;

  assign in_range  = 32'(req_i.frame_number) < 32'(FRAMES);
  assign in_byte_w = 32'(req_i.frame_number) >> 3;
  assign in_byte   = in_byte_w[BW-1:0];

  assign seen  = ram_rdata | ((addr_q == LastByte) ? PadMask : 8'h00);
  assign found = (seen != FULL_BYTE);

  // lowest clear bit of the byte under scan
  always_comb begin
    low_bit = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!seen[k]) begin
        low_bit = 3'(k);
      end
    end
  end

  assign alloc_w  = 32'({addr_q, low_bit});
  assign bit_mask = 8'(8'h01 << bit_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (addr_q == LastByte) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.cmd == CMD_ALLOC) begin
            state_d = ST_SCAN;
          end else if ((req_i.cmd == CMD_FREE || req_i.cmd == CMD_CLAIM) && in_range) begin
            state_d = ST_MOD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (found || addr_q == LastByte) state_d = ST_DONE;
      end
      ST_MOD: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ram_we       = 1'b0;
    ram_wdata    = 8'h00;
    addr_d       = addr_q;
    hint_d       = hint_q;
    cmd_d        = cmd_q;
    bit_d        = bit_q;
    res_frame_d  = res_frame_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_frame_d  = out_frame_q;
    out_status_d = out_status_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        addr_d = (addr_q == LastByte) ? '0 : addr_q + BW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d        = cmd_e'(req_i.cmd);
          bit_d        = req_i.frame_number[2:0];
          res_frame_d  = '0;
          res_status_d = STATUS_DONE;
          addr_d       = (req_i.cmd == CMD_ALLOC) ? hint_q : in_byte;
        end
      end
      ST_SCAN: begin
        if (found) begin
          ram_we      = 1'b1;
          ram_wdata   = ram_rdata | 8'(8'h01 << low_bit);
          hint_d      = addr_q;
          res_frame_d = alloc_w[FRAME_W-1:0];
        end else if (addr_q == LastByte) begin
          res_status_d = STATUS_FULL;
        end else begin
          addr_d = addr_q + BW'(1);
        end
      end
      ST_MOD: begin
        ram_we = 1'b1;
        if (cmd_q == CMD_FREE) begin
          ram_wdata = ram_rdata & ~bit_mask;
          if (hint_q > addr_q) hint_d = addr_q;
        end else begin
          ram_wdata = ram_rdata | bit_mask;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_frame_d  = res_frame_q;
          out_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    bit_q        <= bit_d;
    res_frame_q  <= res_frame_d;
    res_status_q <= res_status_d;
    out_frame_q  <= out_frame_d;
    out_status_q <= out_status_d;
  end

  a_no_item_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !req_i.ready)
    else $error("item taken during bitmap clearing pass");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted item did not start work");

  a_full_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == STATUS_FULL) |-> (rsp_o.alloc_frame == '0))
    else $error("full status with nonzero frame");

  a_write_only_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_SCAN || state_q == ST_MOD))
    else $error("bitmap written outside a read-modify-write step");

  a_hint_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= LastByte)
    else $error("search hint beyond the last byte");

endmodule

// File: tb/sv/page_frame_bitmap_allocator_top_tb.sv
// testbench of page_frame_bitmap_allocator_top: directed, random and dense-block tests
// against a bitmap predictor. depends on pfba_pkg, pfba_if and the allocator rtl
`timescale 1ns / 100ps

module page_frame_bitmap_allocator_top_tb;
  import pfba_pkg::*;

  localparam int unsigned FRAMES       = 4096;
  localparam int unsigned NBYTES       = (FRAMES + 7) / 8;
  localparam int unsigned HALF_PERIOD  = 4;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned DRAIN_CYCLES = NBYTES + 16;
  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [FRAME_W-1:0] alloc_frame;
    logic               status;
  } alloc_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pfba_req_if req_if ();
  pfba_rsp_if rsp_if ();

  page_frame_bitmap_allocator_top #(
    .FRAMES(FRAMES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // predictor state: usage bits and byte search hint
  logic [7:0]  frame_map [NBYTES];
  int unsigned scan_hint;

  alloc_rsp_t  pending_rsp [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_count     = 0;
  int unsigned items_sent    = 0;
  int unsigned rsp_checked   = 0;
  int unsigned full_seen     = 0;
  int unsigned alloc_sent    = 0;
  int unsigned hi_frame      = 0;
  int unsigned cycle_count   = 0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  initial begin
    req_if.valid        <= 1'b0;
    req_if.cmd          <= CMD_NONE;
    req_if.frame_number <= '0;
  end

  // byte as the search sees it: bits past the last frame count as used
  function automatic logic [7:0] byte_view(int unsigned b);
    logic [7:0] v;
    v = frame_map[b];
    for (int k = 0; k < 8; k++) begin
      if (b * 8 + k >= FRAMES) v[k] = 1'b1;
    end
    return v;
  endfunction

  function automatic alloc_rsp_t predict_rsp(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] frame);
    alloc_rsp_t  r;
    int unsigned b;
    int unsigned j;
    logic [7:0]  v;
    r.alloc_frame = '0;
    r.status      = STATUS_DONE;
    b = 0;
    j = 0;
    if (cmd == CMD_ALLOC) begin
      b = scan_hint;
      while (b < NBYTES && byte_view(b) == FULL_BYTE) b++;
      if (b < NBYTES) begin
        v = byte_view(b);
        while (j < 7 && v[j]) j++;
        scan_hint = b;
        frame_map[b][j] = 1'b1;
        r.alloc_frame = FRAME_W'(b * 8 + j);
      end else begin
        r.status = STATUS_FULL;
      end
    end else if (cmd == CMD_FREE) begin
      if (frame < FRAMES) begin
        b = frame >> 3;
        frame_map[b][frame[2:0]] = 1'b0;
        if (scan_hint > b) scan_hint = b;
      end
    end else if (cmd == CMD_CLAIM) begin
      if (frame < FRAMES) frame_map[frame >> 3][frame[2:0]] = 1'b1;
    end
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the item was taken
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] frame);
    alloc_rsp_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= cmd;
    req_if.frame_number <= frame;
    do @(posedge clk_i); while (!req_if.ready);
    r = predict_rsp(cmd, frame);
    pending_rsp.push_back(r);
    items_sent++;
    if (cmd == CMD_ALLOC) begin
      alloc_sent++;
      if (r.status == STATUS_DONE && r.alloc_frame > hi_frame) hi_frame = r.alloc_frame;
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // result side: random ready, in-order compare against the predicted queue
  always @(posedge clk_i or negedge rst_ni) begin : rsp_check
    alloc_rsp_t exp_rsp;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_checked++;
        if (rsp_if.status == STATUS_FULL) full_seen++;
        if (pending_rsp.size() == 0) begin
          err_count++;
          $display("%0t: result with none expected: frame %0d status %0d", $time,
                   rsp_if.alloc_frame, rsp_if.status);
        end else begin
          exp_rsp = pending_rsp.pop_front();
          if (rsp_if.alloc_frame !== exp_rsp.alloc_frame) begin
            err_count++;
            $display("%0t: alloc_frame expected %0d actual %0d", $time,
                     exp_rsp.alloc_frame, rsp_if.alloc_frame);
          end
          if (rsp_if.status !== exp_rsp.status) begin
            err_count++;
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_rsp.status, rsp_if.status);
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // empty map: extremes of the frame field, every command, repeats, hint moves
  task automatic test_directed();
    send_item(CMD_ALLOC, 12'h000);
    send_item(CMD_ALLOC, 12'hfff);       // frame field ignored on allocate
    send_item(CMD_CLAIM, 12'h000);       // claim of a used frame
    send_item(CMD_CLAIM, 12'hfff);
    send_item(CMD_FREE,  12'hfff);
    send_item(CMD_FREE,  12'hfff);       // free of a free frame
    send_item(CMD_NONE,  12'hfff);
    send_item(CMD_NONE,  12'h000);
    for (int f = 2; f < 8; f++) send_item(CMD_CLAIM, FRAME_W'(f));
    send_item(CMD_ALLOC, 12'h555);       // byte zero full, scan moves on
    send_item(CMD_FREE,  12'h003);       // hint back to byte zero
    send_item(CMD_ALLOC, 12'h000);
    send_item(CMD_ALLOC, 12'h000);
    send_item(CMD_CLAIM, 12'h800);
    send_item(CMD_FREE,  12'h800);
    send_item(CMD_FREE,  12'h555);
    send_item(CMD_CLAIM, 12'haaa);
    send_item(CMD_FREE,  12'h000);
  endtask

  function automatic logic [FRAME_W-1:0] rand_frame();
    int unsigned top;
    top = (hi_frame + 24 > FRAMES - 1) ? FRAMES - 1 : hi_frame + 24;
    if ($urandom_range(99) < 65) return FRAME_W'($urandom_range(top));
    return FRAME_W'($urandom_range(FRAMES - 1));
  endfunction

  task automatic test_random(int unsigned n_items, int unsigned s_pct, int unsigned r_pct,
                             bit hold_off);
    int unsigned roll;
    logic [CMD_W-1:0] cmd;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      if (roll < 45)      cmd = CMD_ALLOC;
      else if (roll < 75) cmd = CMD_FREE;
      else if (roll < 93) cmd = CMD_CLAIM;
      else                cmd = CMD_NONE;
      send_item(cmd, rand_frame());
      if (hold_off && i == n_items / 2) wait_drained();
    end
  endtask

  // eight full bytes at the hint: long scans, then a free pulls the hint back
  task automatic test_dense_block();
    int unsigned base;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    base = (scan_hint > NBYTES - 8) ? NBYTES - 8 : scan_hint;
    for (int unsigned f = 0; f < 64; f++) send_item(CMD_CLAIM, FRAME_W'(base * 8 + f));
    for (int i = 0; i < 3; i++) send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, FRAME_W'(base * 8 + 17));
    for (int i = 0; i < 2; i++) send_item(CMD_ALLOC, '1);
    send_item(CMD_CLAIM, FRAME_W'(FRAMES - 1));
    send_item(CMD_FREE,  FRAME_W'(FRAMES - 1));
    send_item(CMD_FREE,  12'h000);
    send_item(CMD_ALLOC, '0);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int b = 0; b < NBYTES; b++) frame_map[b] = '0;
    scan_hint = 0;

    test_directed();
    test_random(200, 9, 88, 1'b0);
    test_random(200, 88, 9, 1'b1);
    test_random(200, 0, 0, 1'b0);
    test_dense_block();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d items (%0d allocates), %0d results checked, %0d full answers",
             items_sent, alloc_sent, rsp_checked, full_seen);
    $display("directed, three idling mixes with a drain pause, multi-byte scans at the hint");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
